[sv/rse_pkg.sv]
// Package: shared types, constants and helpers for the rANS symbol encoder.
package rse_pkg;

  localparam int unsigned StateBitsDef      = 32;
  localparam int unsigned ChunkBitsDef      = 16;
  localparam int unsigned LowerBoundLog2Def = 16;
  localparam int unsigned CodeCountDef      = 256;

  localparam logic [7:0]  RawBaseCode   = 8'd247;
  localparam logic [4:0]  RawMinLength  = 5'd8;
  localparam logic [4:0]  TotalLog2Rst  = 5'd12;
  localparam logic [31:0] InitStateRst  = 32'd65536;

  typedef enum logic [1:0] {
    CMD_TABLE  = 2'd0,
    CMD_ENCODE = 2'd1,
    CMD_FLUSH  = 2'd2,
    CMD_NONE   = 2'd3
  } cmd_e;

  typedef enum logic {
    REG_TOTAL_LOG2    = 1'b0,
    REG_INITIAL_STATE = 1'b1
  } reg_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_LOOKUP,
    ST_CHECK,
    ST_DIV,
    ST_TEST,
    ST_EMIT_CHUNK,
    ST_UPDATE,
    ST_CHUNK_OUT,
    ST_SUFFIX,
    ST_ERROR,
    ST_FLUSH,
    ST_FLUSH_EMIT,
    ST_DONE
  } state_e;

  typedef struct packed {
    logic load;        // capture input item
    logic tbl_write;   // write table entry
    logic lookup;      // read table at code
    logic div_start;   // start divider on current state
    logic shift;       // shift state right by one chunk
    logic update;      // commit rANS update
    logic reload;      // reload initial state
    logic emit;        // push a result into the output register
    logic [1:0] sel;   // result kind
    logic last;        // last flag of the pushed result
  } rse_cmd_t;

  typedef struct packed {
    logic zero_freq;   // looked-up frequency is zero
    logic div_done;    // quotient and remainder ready
    logic over;        // update would overflow or exceed the bound
    logic has_suffix;  // value carries a raw suffix
    logic state_zero;  // working state is zero
    logic out_free;    // output register can take a result
    logic st_last;     // state after next shift is zero (flush)
    logic chk_pend;    // renormalization chunks still to send
    logic chk_last;    // one renormalization chunk left
  } rse_sts_t;

  localparam logic [1:0] SelChunk  = 2'd0;
  localparam logic [1:0] SelSuffix = 2'd1;
  localparam logic [1:0] SelError  = 2'd2;
  localparam logic [1:0] SelHeld   = 2'd3;

  // Bit length of a 16-bit value.
  function automatic logic [4:0] bit_len16(input logic [15:0] v);
    logic [4:0] e;
    e = 5'd0;
    for (int i = 0; i < 16; i++) begin
      if (v[i]) e = 5'(i + 1);
    end
    return e;
  endfunction

endpackage

[sv/rans_symbol_encoder.sv]
// Top level of the rANS symbol encoder.
// One item at a time. An encode item runs from its transfer to the next
// ready through lookup, one radix-2 divide of the state (one quotient bit a
// cycle) plus test, update and return to idle. Each renormalization chunk
// costs one more divide with its test, and every result needs its own
// transfer. Renormalization chunks are sent after the update, once the last
// one is known. A flush sends the state chunk by chunk until it is zero and
// then reloads the initial state. A zero frequency gives one error transfer.
// The table frequency reset uses a valid bit per code, so no clearing pass
// is needed. The output register lets a result wait while the controller
// goes on.
module rans_symbol_encoder import rse_pkg::*; #(
  parameter int unsigned StateBits      = StateBitsDef,
  parameter int unsigned ChunkBits      = ChunkBitsDef,
  parameter int unsigned LowerBoundLog2 = LowerBoundLog2Def,
  parameter int unsigned CodeCount      = CodeCountDef
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic        cfg_idx_i,
  input  logic [31:0] cfg_data_i,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [1:0]  s_axis_tuser,  // cmd
  // [7:0] table_code, [23:8] table_frequency, [39:24] table_cumulative,
  // [55:40] symbol_value
  input  logic [55:0] s_axis_tdata,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [23:0] m_axis_tdata,  // [15:0] chunk_bits, [20:16] chunk_length
  output logic        m_axis_tlast,
  output logic        m_axis_tuser   // error
);

  rse_cmd_t   cmd;
  rse_sts_t   sts;
  logic [4:0] len;

  rse_ctrl u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_valid_i(s_axis_tvalid),
    .cmd_i     (cmd_e'(s_axis_tuser)),
    .in_ready_o(s_axis_tready),
    .sts_i     (sts),
    .cmd_o     (cmd)
  );

  rse_datapath #(
    .StateBits(StateBits), .ChunkBits(ChunkBits),
    .LowerBoundLog2(LowerBoundLog2), .CodeCount(CodeCount)
  ) u_dp (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cfg_we_i          (cfg_we_i),
    .cfg_idx_i         (cfg_idx_i),
    .cfg_data_i        (cfg_data_i),
    .table_code_i      (s_axis_tdata[7:0]),
    .table_frequency_i (s_axis_tdata[23:8]),
    .table_cumulative_i(s_axis_tdata[39:24]),
    .symbol_value_i    (s_axis_tdata[55:40]),
    .cmd_i             (cmd),
    .sts_o             (sts),
    .out_valid_o       (m_axis_tvalid),
    .out_ready_i       (m_axis_tready),
    .chunk_bits_o      (m_axis_tdata[15:0]),
    .chunk_length_o    (len),
    .last_o            (m_axis_tlast),
    .error_o           (m_axis_tuser)
  );

  assign m_axis_tdata[20:16] = len;
  assign m_axis_tdata[23:21] = 3'b000;

endmodule

[sv/rse_ctrl.sv]
// Controller state machine of the rANS symbol encoder.
module rse_ctrl import rse_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  input  cmd_e     cmd_i,
  output logic     in_ready_o,
  input  rse_sts_t sts_i,
  output rse_cmd_t cmd_o
);

  state_e state_q, state_d;
  cmd_e   kind_q, kind_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      kind_q  <= CMD_NONE;
    end else begin
      state_q <= state_d;
      kind_q  <= kind_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    kind_d     = kind_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          kind_d     = cmd_i;
          priority case (cmd_i)
            CMD_TABLE:  begin cmd_o.tbl_write = 1'b1; end
            CMD_ENCODE: state_d = ST_LOOKUP;
            CMD_FLUSH:  state_d = ST_FLUSH;
            default:    state_d = ST_IDLE;
          endcase
        end
      end
      ST_LOOKUP: begin
        cmd_o.lookup = 1'b1;
        state_d      = ST_CHECK;
      end
      ST_CHECK: begin
        if (sts_i.zero_freq) begin
          state_d = ST_ERROR;
        end else begin
          cmd_o.div_start = 1'b1;
          state_d         = ST_DIV;
        end
      end
      ST_DIV: if (sts_i.div_done) state_d = ST_TEST;
      ST_TEST: begin
        if (sts_i.over) begin
          state_d = ST_EMIT_CHUNK;
        end else begin
          state_d = ST_UPDATE;
        end
      end
      ST_EMIT_CHUNK: begin
        // chunk is sent after the update, once its last flag is known
        cmd_o.shift     = 1'b1;
        cmd_o.div_start = 1'b1;
        state_d         = ST_DIV;
      end
      ST_UPDATE: begin
        cmd_o.update = 1'b1;
        if (sts_i.chk_pend) begin
          state_d = ST_CHUNK_OUT;
        end else begin
          state_d = sts_i.has_suffix ? ST_SUFFIX : ST_DONE;
        end
      end
      ST_CHUNK_OUT: begin
        if (sts_i.out_free) begin
          cmd_o.emit = 1'b1;
          cmd_o.sel  = SelHeld;
          cmd_o.last = sts_i.chk_last && !sts_i.has_suffix;
          if (sts_i.chk_last) state_d = sts_i.has_suffix ? ST_SUFFIX : ST_DONE;
        end
      end
      ST_SUFFIX: begin
        if (sts_i.out_free) begin
          cmd_o.emit = 1'b1;
          cmd_o.sel  = SelSuffix;
          cmd_o.last = 1'b1;
          state_d    = ST_DONE;
        end
      end
      ST_ERROR: begin
        if (sts_i.out_free) begin
          cmd_o.emit = 1'b1;
          cmd_o.sel  = SelError;
          cmd_o.last = 1'b1;
          state_d    = ST_DONE;
        end
      end
      ST_FLUSH: begin
        if (sts_i.state_zero) begin
          cmd_o.reload = 1'b1;
          state_d      = ST_DONE;
        end else begin
          state_d = ST_FLUSH_EMIT;
        end
      end
      ST_FLUSH_EMIT: begin
        if (sts_i.out_free) begin
          cmd_o.emit  = 1'b1;
          cmd_o.sel   = SelChunk;
          cmd_o.shift = 1'b1;
          cmd_o.last  = sts_i.st_last;
          state_d     = ST_FLUSH;
        end
      end
      ST_DONE: state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

`ifndef SYNTHESIS
  a_ready_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_ready_o |-> state_q == ST_IDLE)
    else $error("ready outside idle");
  a_emit_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.emit |-> sts_i.out_free)
    else $error("emit without space");
  a_update_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.update |-> $past(state_q) == ST_TEST && !$past(sts_i.over))
    else $error("update without passing test");
`endif

endmodule

[sv/rse_divider.sv]
// Radix-2 restoring divider: one quotient bit per cycle.
module rse_divider import rse_pkg::*; #(
  parameter int unsigned StateBits = StateBitsDef
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 start_i,
  input  logic [StateBits-1:0] dividend_i,
  input  logic [15:0]          divisor_i,
  output logic                 done_o,
  output logic [StateBits-1:0] quot_o,
  output logic [15:0]          rem_o
);

  localparam int unsigned CntW = $clog2(StateBits + 1);

  logic [CntW-1:0]      cnt_q, cnt_d;
  logic                 busy_q, busy_d;
  logic [StateBits-1:0] quot_q, quot_d;
  logic [16:0]          rem_q, rem_d;
  logic [16:0]          trial;

  assign trial = {rem_q[15:0], quot_q[StateBits-1]};

  always_comb begin
    busy_d = busy_q;
    cnt_d  = cnt_q;
    quot_d = quot_q;
    rem_d  = rem_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = CntW'(StateBits);
      quot_d = dividend_i;
      rem_d  = '0;
    end else if (busy_q) begin
      if (trial >= {1'b0, divisor_i}) begin
        rem_d  = trial - {1'b0, divisor_i};
        quot_d = {quot_q[StateBits-2:0], 1'b1};
      end else begin
        rem_d  = trial;
        quot_d = {quot_q[StateBits-2:0], 1'b0};
      end
      cnt_d = cnt_q - 1'b1;
      if (cnt_q == CntW'(1)) busy_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    quot_q <= quot_d;
    rem_q  <= rem_d;
  end

  assign done_o = !busy_q && !start_i;
  assign quot_o = quot_q;
  assign rem_o  = rem_q[15:0];

`ifndef SYNTHESIS
  a_rem_lt: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $fell(busy_q) && divisor_i != 16'd0 |-> rem_q < {1'b0, divisor_i})
    else $error("remainder not below divisor");
  a_cnt: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !busy_q |-> cnt_q == '0 || $past(start_i) == 1'b0)
    else $error("counter out of step");
  a_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_i |=> busy_q)
    else $error("start did not begin division");
`endif

endmodule

[sv/rse_datapath.sv]
// Datapath: table memory, coder state, update arithmetic and output register.
module rse_datapath import rse_pkg::*; #(
  parameter int unsigned StateBits      = StateBitsDef,
  parameter int unsigned ChunkBits      = ChunkBitsDef,
  parameter int unsigned LowerBoundLog2 = LowerBoundLog2Def,
  parameter int unsigned CodeCount      = CodeCountDef
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic        cfg_idx_i,
  input  logic [31:0] cfg_data_i,
  input  logic [7:0]  table_code_i,
  input  logic [15:0] table_frequency_i,
  input  logic [15:0] table_cumulative_i,
  input  logic [15:0] symbol_value_i,
  input  rse_cmd_t    cmd_i,
  output rse_sts_t    sts_o,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [15:0] chunk_bits_o,
  output logic [4:0]  chunk_length_o,
  output logic        last_o,
  output logic        error_o
);

  localparam int unsigned CodeW   = $clog2(CodeCount);
  localparam int unsigned BoundW  = LowerBoundLog2 + ChunkBits;
  localparam int unsigned SumW    = StateBits + 17;

  logic [4:0]           total_log2_q;
  logic [31:0]          init_state_q;
  logic [StateBits-1:0] st_q, st_d;
  logic [StateBits-1:0] held_q;
  logic [3:0]           nchk_q;
  logic [15:0]          value_q;
  logic [4:0]           suf_len_q;
  logic [CodeW-1:0]     code_q;
  logic [15:0]          freq_q, cum_q;
  logic [CodeCount-1:0] valid_q;
  logic [15:0]          freq_mem [CodeCount];
  logic [15:0]          cum_mem  [CodeCount];
  logic                 freq_ok_q;

  logic                 div_done;
  logic [StateBits-1:0] quot;
  logic [15:0]          rem;

  rse_divider #(.StateBits(StateBits)) u_div (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start_i   (cmd_i.div_start),
    .dividend_i(cmd_i.shift ? (st_q >> ChunkBits) : st_q),
    .divisor_i (freq_q),
    .done_o    (div_done),
    .quot_o    (quot),
    .rem_o     (rem)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      total_log2_q <= TotalLog2Rst;
      init_state_q <= InitStateRst;
    end else if (cfg_we_i) begin
      unique case (reg_e'(cfg_idx_i))
        REG_TOTAL_LOG2:    total_log2_q <= cfg_data_i[4:0];
        REG_INITIAL_STATE: init_state_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Code mapping for an encode item.
  logic [4:0]       in_len;
  logic [CodeW-1:0] in_code;
  assign in_len  = bit_len16(symbol_value_i);
  assign in_code = (symbol_value_i < 16'(RawBaseCode)) ? CodeW'(symbol_value_i)
                 : CodeW'(RawBaseCode + 8'(in_len) - 8'(RawMinLength));

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      value_q   <= symbol_value_i;
      suf_len_q <= (symbol_value_i < 16'(RawBaseCode)) ? 5'd0 : in_len;
      code_q    <= in_code;
    end
  end

  // Table memories, valid bit per entry for the frequency reset.
  always_ff @(posedge clk_i) begin
    if (cmd_i.tbl_write) begin
      freq_mem[table_code_i[CodeW-1:0]] <= table_frequency_i;
      cum_mem[table_code_i[CodeW-1:0]]  <= table_cumulative_i;
    end
    if (cmd_i.lookup) begin
      freq_q <= freq_mem[code_q];
      cum_q  <= cum_mem[code_q];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q   <= '0;
      freq_ok_q <= 1'b0;
    end else begin
      if (cmd_i.tbl_write) valid_q[table_code_i[CodeW-1:0]] <= 1'b1;
      if (cmd_i.lookup)    freq_ok_q <= valid_q[code_q];
    end
  end

  // Copy of the state before renormalization; its low chunks go out after the update.
  always_ff @(posedge clk_i) begin
    if (cmd_i.lookup) begin
      held_q <= st_q;
    end else if (cmd_i.emit && cmd_i.sel == SelHeld) begin
      held_q <= held_q >> ChunkBits;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      nchk_q <= '0;
    end else if (cmd_i.lookup) begin
      nchk_q <= '0;
    end else if (cmd_i.shift) begin
      nchk_q <= nchk_q + 4'd1;
    end else if (cmd_i.emit && cmd_i.sel == SelHeld) begin
      nchk_q <= nchk_q - 4'd1;
    end
  end

  // Update arithmetic on the registered quotient.
  logic [SumW-1:0] upd_sum;
  logic            q_over;
  logic [5:0]      lim_sh;
  assign lim_sh  = 6'(StateBits) - 6'(total_log2_q);
  assign q_over  = (32'(total_log2_q) >= StateBits) ? (quot != '0)
                 : ((quot >> lim_sh) != '0);
  assign upd_sum = (SumW'(quot) << total_log2_q) + SumW'(rem) + SumW'(cum_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= StateBits'(InitStateRst);
    end else begin
      st_q <= st_d;
    end
  end

  always_comb begin
    st_d = st_q;
    if (cmd_i.shift)       st_d = st_q >> ChunkBits;
    else if (cmd_i.update) st_d = upd_sum[StateBits-1:0];
    else if (cmd_i.reload) st_d = StateBits'(init_state_q);
  end

  // Output register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_o <= 1'b0;
    end else if (cmd_i.emit) begin
      out_valid_o <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_o <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.emit) begin
      last_o  <= cmd_i.last;
      error_o <= (cmd_i.sel == SelError);
      unique case (cmd_i.sel)
        SelSuffix: begin
          chunk_bits_o   <= value_q;
          chunk_length_o <= suf_len_q;
        end
        SelError: begin
          chunk_bits_o   <= '0;
          chunk_length_o <= '0;
        end
        SelHeld: begin
          chunk_bits_o   <= 16'(held_q[ChunkBits-1:0]);
          chunk_length_o <= 5'(ChunkBits);
        end
        default: begin
          chunk_bits_o   <= 16'(st_q[ChunkBits-1:0]);
          chunk_length_o <= 5'(ChunkBits);
        end
      endcase
    end
  end

  assign sts_o.zero_freq  = !freq_ok_q || freq_q == 16'd0;
  assign sts_o.div_done   = div_done;
  assign sts_o.over       = q_over || (upd_sum > SumW'({BoundW{1'b1}}));
  assign sts_o.has_suffix = suf_len_q != 5'd0;
  assign sts_o.state_zero = st_q == '0;
  assign sts_o.out_free   = !out_valid_o || out_ready_i;
  assign sts_o.st_last    = (st_q >> ChunkBits) == '0;
  assign sts_o.chk_pend   = nchk_q != 4'd0;
  assign sts_o.chk_last   = nchk_q == 4'd1;

`ifndef SYNTHESIS
  a_held_emit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.emit && cmd_i.sel == SelHeld |-> nchk_q != 4'd0)
    else $error("held chunk transfer with none pending");
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i && !cmd_i.emit |=> $stable(chunk_bits_o))
    else $error("stalled result changed");
  a_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(cmd_i.update && cmd_i.shift))
    else $error("update and shift together");
`endif

endmodule
